>>> hdl/gpcr_pkg.sv
// Shared package for the watched-pin change reporter.
// Holds command codes, defaults, and the slot record type.
// No dependencies.
`default_nettype none

package gpcr_pkg;

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_TICK   = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int SLOTS_DEF = 8;
    localparam int PINS_DEF  = 64;

    localparam logic [9:0] MS_PER_S = 10'd1000;

    typedef struct packed {
        logic [5:0]  pin;
        logic [31:0] period_ms;
        logic [31:0] last_time;
        logic        level;
    } t_slot;

    typedef struct packed {
        logic wr;
        logic set_used;
        logic clr_used;
    } t_tbl_ctl;

endpackage

`default_nettype wire

>>> hdl/gpio_periodic_change_reporter_unit.sv
// Top level of the watched-pin change reporter: command sequencer.
// Uses gpcr_pkg, gpcr_alu, gpcr_slot_table, gpcr_level_pick.
//
//  channel   | ports                                            | handshake
//  ----------+--------------------------------------------------+------------------
//  command   | i_cmd i_pin i_period_s i_pull_up i_now_ms        | start & !busy
//            | i_pin_levels                                     |
//  report    | o_event_pin o_event_level o_last                 | o_event_valid,
//            |                                                  | one cycle, no stall
//
// Every accepted add, remove or tick walks the slots one per cycle through one
// shared subtract/compare unit. A tick scans every slot and then flushes; add
// stops at the first free slot and remove at the first used slot with a matching
// pin; both stop at the last slot. Command code 3 is accepted but leaves busy low.
// A report is held until the next reporting slot or the flush and leaves the cycle
// after; the last one comes from the flush.
// Reset is synchronous, active low, and frees every slot. The receiver cannot stall.
`default_nettype none

module gpio_periodic_change_reporter_unit
    import gpcr_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF,
    parameter int PINS  = PINS_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire logic [1:0]      i_cmd,
    input  wire logic [5:0]      i_pin,
    input  wire logic [15:0]     i_period_s,
    input  wire logic            i_pull_up,
    input  wire logic [31:0]     i_now_ms,
    input  wire logic [PINS-1:0] i_pin_levels,
    output logic                 o_event_valid,
    output logic [5:0]           o_event_pin,
    output logic                 o_event_level,
    output logic                 o_last
);

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } t_state;

    t_state            r_state;
    logic [SLOT_W-1:0] r_idx;
    logic [1:0]        r_cmd;
    logic [5:0]        r_pin;
    logic [31:0]       r_pms;
    logic              r_pull_up;
    logic [31:0]       r_now;
    logic [PINS-1:0]   r_levels;
    logic              r_pend_v;
    logic [5:0]        r_pend_pin;
    logic              r_pend_level;
    logic              r_out_v;
    logic [5:0]        r_out_pin;
    logic              r_out_level;
    logic              r_out_last;

    t_slot       w_rd;
    logic        w_rd_used;
    t_slot       w_wr;
    t_tbl_ctl    w_ctl;
    logic [31:0] w_diff;
    logic        w_gt;
    logic        w_lvl;
    logic        w_report;
    logic        w_at_end;
    logic        w_is_add;

    assign busy          = (r_state != ST_IDLE);
    assign o_event_valid = r_out_v;
    assign o_event_pin   = r_out_pin;
    assign o_event_level = r_out_level;
    assign o_last        = r_out_last;

    assign w_is_add = (r_cmd == CMD_ADD);
    assign w_at_end = (r_idx == SLOT_W'(SLOTS - 1));

    gpcr_alu u_alu (
        .i_a      (r_now),
        .i_b      (w_is_add ? r_pms : w_rd.last_time),
        .i_cin    (!w_is_add),
        .i_period (w_rd.period_ms),
        .o_diff   (w_diff),
        .o_gt     (w_gt)
    );

    gpcr_level_pick #(.PINS(PINS)) u_lvl (
        .i_levels (r_levels),
        .i_pin    (w_rd.pin),
        .o_level  (w_lvl)
    );

    gpcr_slot_table #(.SLOTS(SLOTS)) u_tbl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_idx     (r_idx),
        .i_ctl     (w_ctl),
        .i_wr_data (w_wr),
        .o_rd_data (w_rd),
        .o_rd_used (w_rd_used)
    );

    always_comb begin
        if (w_rd.period_ms != 32'd0) begin
            w_report = w_rd_used && w_gt;
        end else begin
            w_report = w_rd_used && (w_lvl != w_rd.level);
        end
    end

    always_comb begin
        w_ctl = '0;
        w_wr  = w_rd;
        if (r_state == ST_SCAN) begin
            unique case (r_cmd)
                CMD_ADD: begin
                    w_wr.pin       = r_pin;
                    w_wr.period_ms = r_pms;
                    w_wr.last_time = w_diff;
                    w_wr.level     = r_pull_up;
                    w_ctl.wr       = !w_rd_used;
                    w_ctl.set_used = !w_rd_used;
                end
                CMD_REMOVE: begin
                    w_ctl.clr_used = w_rd_used && (w_rd.pin == r_pin);
                end
                CMD_TICK: begin
                    w_wr.last_time = r_now;
                    if (w_rd.period_ms == 32'd0) begin
                        w_wr.level = w_lvl;
                    end
                    w_ctl.wr = w_report;
                end
                default: begin
                    w_ctl = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_idx    <= '0;
            r_cmd    <= CMD_ADD;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    r_out_v <= 1'b0;
                    if (start) begin
                        r_cmd      <= i_cmd;
                        r_pin      <= i_pin;
                        r_pms      <= 32'(i_period_s) * 32'(MS_PER_S);
                        r_pull_up  <= i_pull_up;
                        r_now      <= i_now_ms;
                        r_levels   <= i_pin_levels;
                        r_idx      <= '0;
                        r_pend_v   <= 1'b0;
                        if (i_cmd != CMD_UNUSED) begin
                            r_state <= ST_SCAN;
                        end
                    end
                end
                ST_SCAN: begin
                    if (r_cmd == CMD_TICK) begin
                        if (w_report) begin
                            r_out_v      <= r_pend_v;
                            r_out_pin    <= r_pend_pin;
                            r_out_level  <= r_pend_level;
                            r_out_last   <= 1'b0;
                            r_pend_v     <= 1'b1;
                            r_pend_pin   <= w_rd.pin;
                            r_pend_level <= w_lvl;
                        end else begin
                            r_out_v <= 1'b0;
                        end
                        if (w_at_end) begin
                            r_state <= ST_FLUSH;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end else begin
                        r_out_v <= 1'b0;
                        if (w_ctl.set_used || w_ctl.clr_used || w_at_end) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                ST_FLUSH: begin
                    r_out_v     <= r_pend_v;
                    r_out_pin   <= r_pend_pin;
                    r_out_level <= r_pend_level;
                    r_out_last  <= 1'b1;
                    r_pend_v    <= 1'b0;
                    r_state     <= ST_IDLE;
                end
                default: begin
                    r_out_v <= 1'b0;
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    a_strobe_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_event_valid |-> $past(r_state == ST_SCAN || r_state == ST_FLUSH))
        else $error("report transfer without an active tick");

    a_last_from_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_event_valid && o_last) |-> $past(r_state == ST_FLUSH))
        else $error("final report not from flush");

    a_more_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_event_valid && !o_last) |-> r_pend_v)
        else $error("non-final report with nothing pending");

    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> !r_pend_v)
        else $error("pending report left after tick");

    a_cmd_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> (r_cmd != CMD_UNUSED))
        else $error("sequencer running an unused command");

endmodule

`default_nettype wire

>>> hdl/gpcr_alu.sv
// Shared subtract and compare unit for the reporter sequencer.
// Computes a + ~b + cin and a signed "elapsed exceeds period" test.
// Does not import gpcr_pkg; depends on nothing.
`default_nettype none

module gpcr_alu (
    input  wire logic [31:0] i_a,
    input  wire logic [31:0] i_b,
    input  wire logic        i_cin,
    input  wire logic [31:0] i_period,
    output logic      [31:0] o_diff,
    output logic             o_gt
);

    logic [32:0] w_sum;

    assign w_sum  = {1'b0, i_a} + {1'b0, ~i_b} + {32'd0, i_cin};
    assign o_diff = w_sum[31:0];
    assign o_gt   = !o_diff[31] && (o_diff > i_period);

endmodule

`default_nettype wire

>>> hdl/gpcr_slot_table.sv
// Slot table: per-slot used bits (reset) and slot records (no reset).
// One read/write index shared by the sequencer. Depends on gpcr_pkg.
`default_nettype none

module gpcr_slot_table
    import gpcr_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] i_idx,
    input  wire t_tbl_ctl                             i_ctl,
    input  wire t_slot                                i_wr_data,
    output t_slot                                     o_rd_data,
    output logic                                      o_rd_used
);

    t_slot              r_slot [SLOTS];
    logic [SLOTS-1:0]   r_used;

    assign o_rd_data = r_slot[i_idx];
    assign o_rd_used = r_used[i_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (i_ctl.set_used) begin
            r_used[i_idx] <= 1'b1;
        end else if (i_ctl.clr_used) begin
            r_used[i_idx] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr) begin
            r_slot[i_idx] <= i_wr_data;
        end
    end

endmodule

`default_nettype wire

>>> hdl/gpcr_top_sv_placeholder_unused.sv
// Level sampler: picks one pin's level out of the latched pin vector.
// Pins at or above the vector width read as 0. Depends on nothing.
`default_nettype none

module gpcr_level_pick #(
    parameter int PINS = 64
) (
    input  wire logic [PINS-1:0] i_levels,
    input  wire logic [5:0]      i_pin,
    output logic                 o_level
);

    logic [63:0] w_levels64;

    assign w_levels64 = 64'(i_levels);
    assign o_level    = w_levels64[i_pin];

endmodule

`default_nettype wire
